>>> rtl/u8dec_pkg.sv
// Package for the UTF-8 byte stream decoder: field widths, byte masks and the byte classifier.
// It has no dependencies. The decoder and its checker import it.
package u8dec_pkg;

    localparam int BYTE_W       = 8;
    localparam int CP_W         = 21;
    localparam int OUT_TDATA_W  = 24;
    localparam int CP_PAD_W     = OUT_TDATA_W - CP_W;
    localparam int REM_W        = 2;
    localparam int CONT_BITS    = 6;

    localparam logic [BYTE_W-1:0] ASCII_MASK  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_BITS  = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_BITS  = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_BITS  = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE   = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_BMASK  = 8'h3F;

    localparam logic [REM_W-1:0] REM_IDLE  = 2'd0;
    localparam logic [REM_W-1:0] REM_ONE   = 2'd1;
    localparam logic [REM_W-1:0] REM_TWO   = 2'd2;
    localparam logic [REM_W-1:0] REM_THREE = 2'd3;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_CONT,
        KIND_INVALID
    } byte_kind_t;

    function automatic byte_kind_t classify_byte(input logic [BYTE_W-1:0] b);
        byte_kind_t kind;
        if ((b & ASCII_MASK) == '0)
            kind = KIND_ASCII;
        else if ((b & CONT_MASK) == CONT_CODE)
            kind = KIND_CONT;
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
            kind = KIND_LEAD2;
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
            kind = KIND_LEAD3;
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
            kind = KIND_LEAD4;
        else
            kind = KIND_INVALID;
        return kind;
    endfunction

endpackage

>>> rtl/utf8_byte_stream_decoder.sv
// UTF-8 byte stream decoder: one byte in per word, one codepoint out per finished or cut-off sequence.
// Depends on u8dec_pkg for widths, masks and the byte classifier.
//
// Channel  | Direction | tdata                      | tlast
// s_axis   | in        | [7:0] data_byte            | string_end
// m_axis   | out       | [20:0] code_point, pad 0   | last_of_string
//
// A byte is registered on acceptance and then decoded into the result register. While no result
// is held back by a low m_axis_tready, one byte is taken every cycle. The single decode step
// lies between the input and result registers.
// When a result is held because m_axis_tready is low, a byte that would produce another result
// waits in the input register and s_axis_tready falls; bytes that produce no result still move.
// Reset clears the decode state and both valid flags.
module utf8_byte_stream_decoder
    import u8dec_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic                   m_axis_tlast
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    logic [CP_W-1:0]   acc_reg;
    logic [CP_W-1:0]   acc_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;

    logic              out_valid_reg;
    logic [CP_W-1:0]   out_cp_reg;
    logic              out_last_reg;

    logic              emit;
    logic [CP_W-1:0]   emit_cp;
    logic              advance;
    logic              in_fire;
    logic [CP_W-1:0]   shifted;
    logic [REM_W-1:0]  rem_dec;
    byte_kind_t        kind;

    assign kind    = classify_byte(in_byte_reg);
    assign shifted = CP_W'({acc_reg, CONT_BITS'(in_byte_reg & CONT_BMASK)});
    assign rem_dec = rem_reg - REM_ONE;

    always_comb
    begin
        emit     = 1'b0;
        emit_cp  = acc_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        if (rem_reg == REM_IDLE)
        begin
            unique case (kind)
                KIND_ASCII:
                begin
                    emit     = 1'b1;
                    emit_cp  = CP_W'(in_byte_reg);
                    acc_next = '0;
                end
                KIND_LEAD2:
                begin
                    emit_cp  = CP_W'(in_byte_reg & LEAD2_BITS);
                    acc_next = emit_cp;
                    rem_next = REM_ONE;
                end
                KIND_LEAD3:
                begin
                    emit_cp  = CP_W'(in_byte_reg & LEAD3_BITS);
                    acc_next = emit_cp;
                    rem_next = REM_TWO;
                end
                KIND_LEAD4:
                begin
                    emit_cp  = CP_W'(in_byte_reg & LEAD4_BITS);
                    acc_next = emit_cp;
                    rem_next = REM_THREE;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
            if (in_last_reg && (kind == KIND_LEAD2 || kind == KIND_LEAD3 || kind == KIND_LEAD4))
            begin
                emit     = 1'b1;
                acc_next = '0;
                rem_next = REM_IDLE;
            end
        end
        else if (kind != KIND_CONT)
        begin
            emit     = 1'b1;
            emit_cp  = acc_reg;
            acc_next = '0;
            rem_next = REM_IDLE;
        end
        else
        begin
            emit_cp  = shifted;
            acc_next = shifted;
            rem_next = rem_dec;
            if (rem_dec == REM_IDLE || in_last_reg)
            begin
                emit     = 1'b1;
                acc_next = '0;
                rem_next = REM_IDLE;
            end
        end
    end

    assign advance       = in_valid_reg && (!emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            rem_reg       <= REM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                acc_reg <= acc_next;
                rem_reg <= rem_next;
            end
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && emit)
        begin
            out_cp_reg   <= emit_cp;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{CP_PAD_W{1'b0}}, out_cp_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> rtl/u8dec_checker.sv
// Port-level checker for the UTF-8 byte stream decoder, bound to every instance of it.
// Depends on u8dec_pkg for widths.
module u8dec_checker
    import u8dec_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    // A held output word keeps its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // The input side only stalls when a result is waiting on a blocked output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a blocked output");

    // A fresh output word follows an accepted input byte.
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("output word without a preceding input word");

    // Codepoints never use the padding bits.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:CP_W] == '0)
        else $error("padding bits of the codepoint are set");

endmodule

bind utf8_byte_stream_decoder u8dec_checker u_u8dec_checker (.*);

>>> tb/tb_utf8_byte_stream_decoder.sv
// Self-checking testbench for the UTF-8 byte stream decoder, driven over its two stream ports.
// Depends on u8dec_pkg for widths and byte masks, and on utf8_byte_stream_decoder
// as the block under test.
`timescale 1ns / 100ps

module tb_utf8_byte_stream_decoder;
    import u8dec_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int PHASE_WORDS  = 262;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
    } cp_result_t;

    class cp_scoreboard;
        logic [CP_W-1:0]  acc;
        logic [REM_W-1:0] remaining;
        cp_result_t       expected_cps[$];
        int               errors;
        int               bytes_in;
        int               cps_out;
        int               ends_out;

        function new();
            acc       = '0;
            remaining = REM_IDLE;
            errors    = 0;
            bytes_in  = 0;
            cps_out   = 0;
            ends_out  = 0;
        endfunction

        function void push_cp(input logic [CP_W-1:0] cp, input logic last);
            cp_result_t r;
            r.cp         = cp;
            r.last       = last;
            expected_cps = {expected_cps, r};
            acc          = '0;
            remaining    = REM_IDLE;
        endfunction

        function void decode_byte(input logic [BYTE_W-1:0] b, input logic str_end);
            bytes_in++;
            if (remaining == REM_IDLE)
            begin
                if ((b & ASCII_MASK) == '0)
                begin
                    push_cp(CP_W'(b), str_end);
                    return;
                end
                if ((b & LEAD2_MASK) == LEAD2_CODE)
                begin
                    acc       = CP_W'(b & LEAD2_BITS);
                    remaining = REM_ONE;
                end
                else if ((b & LEAD3_MASK) == LEAD3_CODE)
                begin
                    acc       = CP_W'(b & LEAD3_BITS);
                    remaining = REM_TWO;
                end
                else if ((b & LEAD4_MASK) == LEAD4_CODE)
                begin
                    acc       = CP_W'(b & LEAD4_BITS);
                    remaining = REM_THREE;
                end
                else
                begin
                    return;
                end
                if (str_end)
                    push_cp(acc, 1'b1);
                return;
            end
            if ((b & CONT_MASK) != CONT_CODE)
            begin
                push_cp(acc, str_end);
                return;
            end
            acc       = (acc << CONT_BITS) | CP_W'(b & CONT_BMASK);
            remaining = remaining - 1'b1;
            if (remaining == REM_IDLE || str_end)
                push_cp(acc, str_end);
        endfunction

        function void check_word(input logic [OUT_TDATA_W-1:0] d, input logic last);
            cp_result_t e;
            if (expected_cps.size() == 0)
            begin
                $error("unexpected word: code_point %h last_of_string %b", d[CP_W-1:0], last);
                errors++;
                return;
            end
            e = expected_cps.pop_front();
            cps_out++;
            if (last)
                ends_out++;
            if (d[CP_W-1:0] !== e.cp)
            begin
                $error("code_point: expected %h, got %h", e.cp, d[CP_W-1:0]);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last_of_string: expected %b, got %b", e.last, last);
                errors++;
            end
            if (d[OUT_TDATA_W-1:CP_W] !== '0)
            begin
                $error("pad: expected %h, got %h", CP_PAD_W'(0), d[OUT_TDATA_W-1:CP_W]);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    int           src_idle_pct = 0;
    int           sink_stall_pct = 0;
    logic         sink_hold = 1'b0;
    int           cycles = 0;
    int           phase_words;
    cp_scoreboard sb = new();

    utf8_byte_stream_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (sink_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tlast);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.decode_byte(s_axis_tdata, s_axis_tlast);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("[utf8_byte_stream_decoder] ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic str_end);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= str_end;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Sends the first n_sent bytes of a random sequence of n_bytes.
    // The end mark goes on the final byte sent.
    task automatic send_utf8(input int n_bytes, input int n_sent, input logic str_end);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < n_sent; i++)
        begin
            if (i == 0)
            begin
                case (n_bytes)
                    1: b = BYTE_W'($urandom_range(127));
                    2: b = LEAD2_CODE | (BYTE_W'($urandom) & LEAD2_BITS);
                    3: b = LEAD3_CODE | (BYTE_W'($urandom) & LEAD3_BITS);
                    default: b = LEAD4_CODE | (BYTE_W'($urandom) & LEAD4_BITS);
                endcase
            end
            else
            begin
                b = CONT_CODE | (BYTE_W'($urandom) & CONT_BMASK);
            end
            send_byte(b, (i == n_sent - 1) ? str_end : 1'b0);
        end
        phase_words += n_sent;
    endtask

    initial
    begin
        logic [BYTE_W-1:0] b;
        int                n;
        int                pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hE5, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hFE, 1'b1);
        send_byte(8'h20, 1'b0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 60;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 60;
                end
                default:
                begin
                    src_idle_pct   = 6;
                    sink_stall_pct = 6;
                end
            endcase
            if (phase == 0)
            begin
                fork
                    begin
                        sink_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        sink_hold <= 1'b0;
                    end
                join_none
            end
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                pick = $urandom_range(99);
                n    = $urandom_range(1, 4);
                if (pick < 70)
                begin
                    send_utf8(n, n, ($urandom_range(5) == 0));
                end
                else if (pick < 82)
                begin
                    n = $urandom_range(2, 4);
                    send_utf8(n, $urandom_range(1, n - 1), 1'b0);
                    do
                        b = BYTE_W'($urandom);
                    while ((b & CONT_MASK) == CONT_CODE);
                    send_byte(b, 1'($urandom_range(1)));
                    phase_words++;
                end
                else if (pick < 92)
                begin
                    n = $urandom_range(2, 4);
                    send_utf8(n, $urandom_range(1, n - 1), 1'b1);
                end
                else
                begin
                    send_byte(BYTE_W'($urandom), ($urandom_range(3) == 0));
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.expected_cps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input words and %0d codepoints, %0d of them closing a string,",
                 sb.bytes_in, sb.cps_out, sb.ends_out);
        $display("under free flow, sender gaps, receiver stalls, both, and a long receiver hold-off.");
        if (sb.errors == 0)
            $display("[utf8_byte_stream_decoder] OK");
        else
            $display("[utf8_byte_stream_decoder] ERROR");
        $finish;
    end

endmodule
